### src/mc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc_pkg: shared types and code tables for the Morse codec
// Beat types for both channels, the decode tree and the letter code table.
// ----------------------------------------------------------------------------
package mc_pkg;

  // Most results one input beat can cause: four symbols and a space
  localparam int unsigned MaxRes   = 5;
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);
  localparam int unsigned MaxDepth = 4;
  localparam int unsigned DepthW   = $clog2(MaxDepth + 1);
  localparam int unsigned NodeW    = 5;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChNone  = 8'h00;

  localparam logic DirDecode = 1'b0;
  localparam logic DirEncode = 1'b1;

  typedef struct packed {
    logic [7:0] in_char;
    logic       line_end;
  } mc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       bad_code;
    logic       run_last;
  } mc_out_t;

  // One pending result without the last marker
  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
  } mc_res_t;

  // Position of the decoder in the code tree
  typedef struct packed {
    logic [NodeW-1:0]  idx;
    logic [DepthW-1:0] len;
    logic              off;
  } mc_path_t;

  // Code of one letter: symbol i is a dash when bit i is set
  typedef struct packed {
    logic [DepthW-1:0]   len;
    logic [MaxDepth-1:0] dash;
  } mc_code_t;

  // Letter at a tree node; zero where the node holds no letter
  function automatic logic [7:0] tree_letter(input logic [NodeW-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      5'd0:  ch = ChSpace;
      5'd1:  ch = "E";
      5'd2:  ch = "T";
      5'd3:  ch = "I";
      5'd4:  ch = "A";
      5'd5:  ch = "N";
      5'd6:  ch = "M";
      5'd7:  ch = "S";
      5'd8:  ch = "U";
      5'd9:  ch = "R";
      5'd10: ch = "W";
      5'd11: ch = "D";
      5'd12: ch = "K";
      5'd13: ch = "G";
      5'd14: ch = "O";
      5'd15: ch = "H";
      5'd16: ch = "V";
      5'd17: ch = "F";
      5'd19: ch = "L";
      5'd21: ch = "P";
      5'd22: ch = "J";
      5'd23: ch = "B";
      5'd24: ch = "X";
      5'd25: ch = "C";
      5'd26: ch = "Y";
      5'd27: ch = "Z";
      5'd28: ch = "Q";
      default: ch = ChNone;
    endcase
    return ch;
  endfunction

  // Dot and dash pattern of letter A + li
  function automatic mc_code_t letter_code(input logic [4:0] li);
    mc_code_t c;
    unique case (li)
      5'd0:  c = '{len: 3'd2, dash: 4'b0010};
      5'd1:  c = '{len: 3'd4, dash: 4'b0001};
      5'd2:  c = '{len: 3'd4, dash: 4'b0101};
      5'd3:  c = '{len: 3'd3, dash: 4'b0001};
      5'd4:  c = '{len: 3'd1, dash: 4'b0000};
      5'd5:  c = '{len: 3'd4, dash: 4'b0100};
      5'd6:  c = '{len: 3'd3, dash: 4'b0011};
      5'd7:  c = '{len: 3'd4, dash: 4'b0000};
      5'd8:  c = '{len: 3'd2, dash: 4'b0000};
      5'd9:  c = '{len: 3'd4, dash: 4'b1110};
      5'd10: c = '{len: 3'd3, dash: 4'b0101};
      5'd11: c = '{len: 3'd4, dash: 4'b0010};
      5'd12: c = '{len: 3'd2, dash: 4'b0011};
      5'd13: c = '{len: 3'd2, dash: 4'b0001};
      5'd14: c = '{len: 3'd3, dash: 4'b0111};
      5'd15: c = '{len: 3'd4, dash: 4'b0110};
      5'd16: c = '{len: 3'd4, dash: 4'b1011};
      5'd17: c = '{len: 3'd3, dash: 4'b0010};
      5'd18: c = '{len: 3'd3, dash: 4'b0000};
      5'd19: c = '{len: 3'd1, dash: 4'b0001};
      5'd20: c = '{len: 3'd3, dash: 4'b0100};
      5'd21: c = '{len: 3'd4, dash: 4'b1000};
      5'd22: c = '{len: 3'd3, dash: 4'b0110};
      5'd23: c = '{len: 3'd4, dash: 4'b1001};
      5'd24: c = '{len: 3'd4, dash: 4'b1101};
      5'd25: c = '{len: 3'd4, dash: 4'b0011};
      default: c = '{len: 3'd0, dash: 4'b0000};
    endcase
    return c;
  endfunction

endpackage

### src/morse_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_codec: Morse code encoder and decoder for the letters A to Z
// Decodes dot and dash characters to letters or encodes letters to Morse.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | beat
//  in       | sink      | in_valid/in_ready   | in_char, line_end
//  out      | source    | out_valid/out_ready | out_char, bad_code, run_last
//  cfg      | sink      | cfg_we (no wait)    | direction
//
//  An input beat is translated combinationally into a result buffer of up to five
//  entries; the buffer drains one result per cycle while out_ready_i is high, so a
//  beat yields one output beat per result (encode: one for a space or an
//  unknown character, else code length plus one, two to five; decode: zero to
//  two). A beat with no result leaves the buffer empty.
//  The next beat is taken in the cycle the last buffered result leaves.
//  Reset clears the direction to decode and the path to the tree root.
//  A stall on the output holds the buffer and blocks the input.
// ----------------------------------------------------------------------------
module morse_codec (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire mc_pkg::mc_in_t  in_beat_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output mc_pkg::mc_out_t      out_beat_o
);
  import mc_pkg::*;

  logic                   direction_q;
  mc_path_t               path_q;
  mc_path_t               path_d;
  mc_res_t [MaxRes-1:0]   res_q;
  mc_res_t [MaxRes-1:0]   res_d;
  logic [ResCntW-1:0]     cnt_q;
  logic [ResCntW-1:0]     cnt_d;
  logic [ResCntW-1:0]     new_cnt;
  logic                   in_fire;
  logic                   out_fire;

  // Translate the incoming beat
  mc_xlate u_xlate (
    .dir_i  (direction_q),
    .beat_i (in_beat_i),
    .path_i (path_q),
    .res_o  (res_d),
    .cnt_o  (new_cnt),
    .path_o (path_d)
  );

  // Accept when the buffer is empty or its last result leaves now
  assign out_valid_o = (cnt_q != '0);
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Present the head of the buffer
  assign out_beat_o.out_char = res_q[0].ch;
  assign out_beat_o.bad_code = res_q[0].bad;
  assign out_beat_o.run_last = (cnt_q == ResCntW'(1));

  // Next fill level
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = new_cnt;
    end else if (out_fire) begin
      cnt_d = cnt_q - ResCntW'(1);
    end
  end

  // Hold control state: direction, tree position, fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DirDecode;
      path_q      <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        direction_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        path_q <= path_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // Load a new result list, or advance the buffer by one beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end else if (out_fire) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  // Fill level never exceeds the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(MaxRes))
    else $error("result count above buffer depth");

  // The path is only marked off the tree at full depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    path_q.off |-> (path_q.len == DepthW'(MaxDepth)))
    else $error("off-tree flag below full depth");

  // An empty path sits at the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (path_q.len == '0) |-> (path_q.idx == '0))
    else $error("empty path away from the root");

  // Every beat taken in encode mode yields at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (direction_q == DirEncode)) |=> out_valid_o)
    else $error("encode beat produced no result");

  // Encoding leaves the tree position alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (direction_q == DirEncode)) |=> $stable(path_q))
    else $error("encode beat moved the decode path");

endmodule
`default_nettype wire

### src/mc_xlate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mc_xlate: single-pass translation of one input beat
// Builds the list of results for one beat and the next tree position.
// ----------------------------------------------------------------------------
module mc_xlate (
  input  wire logic                                  dir_i,
  input  wire mc_pkg::mc_in_t                        beat_i,
  input  wire mc_pkg::mc_path_t                      path_i,
  output mc_pkg::mc_res_t [mc_pkg::MaxRes-1:0]       res_o,
  output logic [mc_pkg::ResCntW-1:0]                 cnt_o,
  output mc_pkg::mc_path_t                           path_o
);
  import mc_pkg::*;

  logic       is_space;
  logic       is_dash;
  logic       is_letter;
  logic [4:0] li;
  mc_code_t   code;
  mc_path_t   step;
  mc_res_t    emit_now;
  mc_res_t    emit_eol;
  logic [7:0] ch_now;
  logic [7:0] ch_eol;

  assign is_space  = (beat_i.in_char == ChSpace);
  assign is_dash   = (beat_i.in_char == ChDash);
  assign is_letter = ((beat_i.in_char >= "A") && (beat_i.in_char <= "Z")) ||
                     ((beat_i.in_char >= "a") && (beat_i.in_char <= "z"));
  // Both cases share the low five bits: A and a give 1
  assign li        = beat_i.in_char[4:0] - 5'd1;
  assign code      = letter_code(li);

  // Advance the path by one symbol, or mark it off the tree past depth four
  always_comb begin
    step = path_i;
    if (path_i.off || (path_i.len >= DepthW'(MaxDepth))) begin
      step.off = 1'b1;
    end else begin
      step.idx = {path_i.idx[NodeW-2:0], 1'b0} + (is_dash ? 5'd2 : 5'd1);
      step.len = path_i.len + 3'd1;
    end
  end

  // Letter emitted by a space, taken from the current path
  assign ch_now   = tree_letter(path_i.idx);
  assign emit_now = path_i.off ? '{ch: ChNone, bad: 1'b1}
                               : '{ch: ch_now, bad: (ch_now == ChNone)};

  // Letter emitted by the line end flush, after this beat's symbol
  assign ch_eol   = tree_letter(step.idx);
  always_comb begin
    if (is_space) begin
      emit_eol = '{ch: ChSpace, bad: 1'b0};
    end else if (step.off) begin
      emit_eol = '{ch: ChNone, bad: 1'b1};
    end else begin
      emit_eol = '{ch: ch_eol, bad: (ch_eol == ChNone)};
    end
  end

  // Assemble the result list and the next tree position
  always_comb begin
    res_o  = '0;
    cnt_o  = '0;
    path_o = path_i;
    if (dir_i == DirEncode) begin
      if (is_space) begin
        res_o[0] = '{ch: ChSpace, bad: 1'b0};
        cnt_o    = ResCntW'(1);
      end else if (is_letter) begin
        for (int i = 0; i < MaxRes; i++) begin
          res_o[i] = '{ch: ChSpace, bad: 1'b0};
        end
        for (int i = 0; i < MaxDepth; i++) begin
          if (DepthW'(i) < code.len) begin
            res_o[i] = '{ch: code.dash[i] ? ChDash : ChDot, bad: 1'b0};
          end
        end
        cnt_o = ResCntW'(code.len) + ResCntW'(1);
      end else begin
        res_o[0] = '{ch: ChNone, bad: 1'b1};
        cnt_o    = ResCntW'(1);
      end
    end else begin
      if (is_space) begin
        res_o[0] = emit_now;
        cnt_o    = ResCntW'(1);
        path_o   = '0;
        if (beat_i.line_end) begin
          res_o[1] = emit_eol;
          cnt_o    = ResCntW'(2);
        end
      end else begin
        path_o = step;
        if (beat_i.line_end) begin
          res_o[0] = emit_eol;
          cnt_o    = ResCntW'(1);
          path_o   = '0;
        end
      end
    end
  end

endmodule
`default_nettype wire
